FILE: rtl/lgp_pkg.sv
// Shared constants, stage control struct and factor-table functions for the
// gamma-corrected luminance core. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package lgp_pkg;

   localparam int LGP_CHANNEL_BITS_DEF = 8;

   localparam int WEIGHT_W   = 16;
   localparam int GAMMA_W    = 16;
   localparam int LUMA_FRAC  = 8;
   localparam int LOG_FRAC   = 28;
   localparam int GAMMA_FRAC = 12;
   localparam int PROD_FRAC  = 40;
   localparam int MANT_FRAC  = 30;
   localparam int MANT_W     = MANT_FRAC + 1;
   localparam int SHAMT_W    = 5;
   // luma fraction offset is 8 * gamma in Q.40, i.e. gamma << (LOG_FRAC + 3)
   localparam int OFFS_SHIFT = LOG_FRAC + 3;

   localparam logic [WEIGHT_W-1:0] W_RED   = 16'd19661;
   localparam logic [WEIGHT_W-1:0] W_GREEN = 16'd38666;
   localparam logic [WEIGHT_W-1:0] W_BLUE  = 16'd7209;

   localparam logic [GAMMA_W-1:0] LGP_GAMMA_RESET = 16'd5734;

   // sideband that travels with each item down the pipe
   typedef struct packed {
      logic               valid;
      logic               zero;   // luminance was zero
      logic               big;    // integer part of exponent >= channel bits
      logic               neg;    // exponent below zero
      logic               shz;    // right shift clears the mantissa
      logic [SHAMT_W-1:0] shamt;
   } lgp_ctl_type;

   function automatic logic [63:0] lgp_isqrt(input logic [63:0] v_arg);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] bit_q;
      v     = v_arg;
      res   = '0;
      bit_q = 64'h1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (bit_q > v) bit_q = bit_q >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (bit_q != '0) begin
            if (v >= res + bit_q) begin
               v   = v - (res + bit_q);
               res = (res >> 1) + bit_q;
            end else begin
               res = res >> 1;
            end
            bit_q = bit_q >> 2;
         end
      end
      return res;
   endfunction

   // 2^(2^-k) in Q1.30, by repeated square roots of 2.0
   function automatic logic [MANT_W-1:0] lgp_pow_factor(input int k);
      logic [63:0] t;
      t = 64'd2 << MANT_FRAC;
      for (int j = 1; j <= LOG_FRAC; j++) begin
         if (j <= k) t = lgp_isqrt(t << MANT_FRAC);
      end
      return t[MANT_W-1:0];
   endfunction

endpackage

`default_nettype wire

FILE: rtl/lgp_if.sv
// Channel interfaces of the luminance core: pixel request, gray response and
// the gamma register write port. Depends on lgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lgp_req_if import lgp_pkg::*; #(
   parameter int CHANNEL_BITS = LGP_CHANNEL_BITS_DEF
) ();
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] red_in;
   logic [CHANNEL_BITS-1:0] green_in;
   logic [CHANNEL_BITS-1:0] blue_in;

   modport source (output valid, output red_in, output green_in, output blue_in,
                   input ready);
   modport sink   (input valid, input red_in, input green_in, input blue_in,
                   output ready);
endinterface

interface lgp_rsp_if import lgp_pkg::*; #(
   parameter int CHANNEL_BITS = LGP_CHANNEL_BITS_DEF
) ();
   logic                    valid;
   logic                    ready;
   logic [CHANNEL_BITS-1:0] gray_out;
   logic                    clamped;

   modport source (output valid, output gray_out, output clamped, input ready);
   modport sink   (input valid, input gray_out, input clamped, output ready);
endinterface

interface lgp_csr_if import lgp_pkg::*; ();
   logic               valid;
   logic               ready;
   logic [GAMMA_W-1:0] gamma_exponent;

   modport source (output valid, output gamma_exponent, input ready);
   modport sink   (input valid, input gamma_exponent, output ready);
endinterface

`default_nettype wire

FILE: rtl/lgp_front.sv
// Front end: weighted luminance sum, leading-one search and mantissa
// normalization, three register stages. Depends on lgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgp_front import lgp_pkg::*; #(
   parameter int CHANNEL_BITS = LGP_CHANNEL_BITS_DEF,
   parameter int LUMA_W       = CHANNEL_BITS + LUMA_FRAC,
   parameter int P_W          = $clog2(LUMA_W)
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    adv,
   input  logic                    up_valid,
   input  logic [CHANNEL_BITS-1:0] red_in,
   input  logic [CHANNEL_BITS-1:0] green_in,
   input  logic [CHANNEL_BITS-1:0] blue_in,
   output lgp_ctl_type             dn_ctl,
   output logic [P_W-1:0]          dn_p,
   output logic [MANT_W-1:0]       dn_x
);

   localparam int SUM_W = CHANNEL_BITS + WEIGHT_W;
   localparam logic [P_W-1:0] TOP_POS = P_W'(LUMA_W - 1);

   logic [SUM_W-1:0]  sum;
   logic              v1_ff, v2_ff, v3_ff;
   logic [LUMA_W-1:0] luma1_in, luma1_ff;
   logic [LUMA_W-1:0] luma2_ff;
   logic [P_W-1:0]    p2_in, p2_ff, p3_ff;
   logic              zero2_in, zero2_ff, zero3_ff;
   logic [LUMA_W-1:0] aligned;
   logic [MANT_W-1:0] x3_in, x3_ff;

   // weights sum to 1.0, so the sum fits in CHANNEL_BITS + 16 bits
   assign sum = SUM_W'(W_RED) * SUM_W'(red_in) + SUM_W'(W_GREEN) * SUM_W'(green_in)
              + SUM_W'(W_BLUE) * SUM_W'(blue_in);
   assign luma1_in = sum[SUM_W-1:LUMA_FRAC];

   always_comb begin
      p2_in = '0;
      for (int i = 0; i < LUMA_W; i++) begin
         if (luma1_ff[i]) p2_in = P_W'(i);
      end
   end
   assign zero2_in = (luma1_ff == '0);

   // msb lands on bit 30: Q1.30 mantissa in [1, 2)
   assign aligned = luma2_ff << (TOP_POS - p2_ff);
   assign x3_in   = {aligned, {(MANT_W - LUMA_W){1'b0}}};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else if (adv) begin
         v1_ff <= up_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         luma1_ff <= luma1_in;
         luma2_ff <= luma1_ff;
         p2_ff    <= p2_in;
         zero2_ff <= zero2_in;
         p3_ff    <= p2_ff;
         zero3_ff <= zero2_ff;
         x3_ff    <= x3_in;
      end
   end

   always_comb begin
      dn_ctl       = '0;
      dn_ctl.valid = v3_ff;
      dn_ctl.zero  = zero3_ff;
   end
   assign dn_p = p3_ff;
   assign dn_x = x3_ff;

endmodule

`default_nettype wire

FILE: rtl/lgp_log_stage.sv
// One log2 fraction bit: square the Q1.30 mantissa and renormalize.
// Depends on lgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgp_log_stage import lgp_pkg::*; #(
   parameter int P_W = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  lgp_ctl_type         up_ctl,
   input  logic [P_W-1:0]      up_p,
   input  logic [MANT_W-1:0]   up_x,
   input  logic [LOG_FRAC-1:0] up_frac,
   output lgp_ctl_type         dn_ctl,
   output logic [P_W-1:0]      dn_p,
   output logic [MANT_W-1:0]   dn_x,
   output logic [LOG_FRAC-1:0] dn_frac
);

   logic [2*MANT_W-1:0] sq;
   logic [MANT_W:0]     t;
   logic [MANT_W-1:0]   x_in;
   logic [LOG_FRAC-1:0] frac_in;
   lgp_ctl_type         ctl_ff;
   logic [P_W-1:0]      p_ff;
   logic [MANT_W-1:0]   x_ff;
   logic [LOG_FRAC-1:0] frac_ff;

   assign sq = (2*MANT_W)'(up_x) * (2*MANT_W)'(up_x);
   assign t  = sq[2*MANT_W-1:MANT_FRAC];

   // square reached 2.0: fraction bit is 1, halve back into [1, 2)
   assign x_in    = t[MANT_W] ? t[MANT_W:1] : t[MANT_W-1:0];
   assign frac_in = {up_frac[LOG_FRAC-2:0], t[MANT_W]};

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         p_ff    <= up_p;
         x_ff    <= x_in;
         frac_ff <= frac_in;
      end
   end

   assign dn_ctl  = ctl_ff;
   assign dn_p    = p_ff;
   assign dn_x    = x_ff;
   assign dn_frac = frac_ff;

endmodule

`default_nettype wire

FILE: rtl/lgp_mid.sv
// Exponent scaling: log2 times gamma, removal of the luma fraction offset,
// split into shift and exp2 fraction. Three stages. Depends on lgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgp_mid import lgp_pkg::*; #(
   parameter int CHANNEL_BITS = LGP_CHANNEL_BITS_DEF,
   parameter int P_W          = 4
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  logic [GAMMA_W-1:0]  gamma,
   input  lgp_ctl_type         up_ctl,
   input  logic [P_W-1:0]      up_p,
   input  logic [LOG_FRAC-1:0] up_frac,
   output lgp_ctl_type         dn_ctl,
   output logic [LOG_FRAC-1:0] dn_f
);

   localparam int LG_W   = P_W + LOG_FRAC;
   localparam int PROD_W = LG_W + GAMMA_W;
   localparam int OFFS_W = GAMMA_W + OFFS_SHIFT;
   localparam int D_W    = (PROD_W > OFFS_W) ? PROD_W : OFFS_W;
   localparam int IP_W   = D_W - PROD_FRAC;

   lgp_ctl_type         ctl1_ff, ctl2_ff, ctl3_ff, ctl3_in;
   logic [PROD_W-1:0]   prod1_in, prod1_ff;
   logic [D_W-1:0]      prod_d, offs, d2_in, d2_ff;
   logic                neg2_in, neg2_ff;
   logic [IP_W-1:0]     ipart;
   logic [PROD_FRAC-1:0] fpart, fneg;
   logic                fnz;
   logic [IP_W:0]       shn;
   logic [LOG_FRAC-1:0] f3_in, f3_ff;

   assign prod1_in = PROD_W'({up_p, up_frac}) * PROD_W'(gamma);

   assign prod_d  = D_W'(prod1_ff);
   assign offs    = D_W'({gamma, {OFFS_SHIFT{1'b0}}});
   assign neg2_in = (prod_d < offs);
   assign d2_in   = neg2_in ? (offs - prod_d) : (prod_d - offs);

   assign ipart = d2_ff[D_W-1:PROD_FRAC];
   assign fpart = d2_ff[PROD_FRAC-1:0];
   assign fnz   = (fpart != '0);
   // negative exponent: floor toward minus infinity, fraction becomes 1 - frac
   assign fneg  = ~fpart + PROD_FRAC'(1);
   assign shn   = (IP_W + 1)'(ipart) + (IP_W + 1)'(fnz);

   always_comb begin
      ctl3_in     = ctl2_ff;
      ctl3_in.neg = neg2_ff;
      ctl3_in.big = !neg2_ff && (ipart >= IP_W'(CHANNEL_BITS));
      ctl3_in.shz = neg2_ff && (shn >= (IP_W + 1)'(MANT_W));
      if (neg2_ff) begin
         ctl3_in.shamt = shn[SHAMT_W-1:0];
         f3_in         = fneg[PROD_FRAC-1:GAMMA_FRAC];
      end else begin
         ctl3_in.shamt = ipart[SHAMT_W-1:0];
         f3_in         = fpart[PROD_FRAC-1:GAMMA_FRAC];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
      end else if (adv) begin
         ctl1_ff <= up_ctl;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl3_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         prod1_ff <= prod1_in;
         d2_ff    <= d2_in;
         neg2_ff  <= neg2_in;
         f3_ff    <= f3_in;
      end
   end

   assign dn_ctl = ctl3_ff;
   assign dn_f   = f3_ff;

endmodule

`default_nettype wire

FILE: rtl/lgp_exp_stage.sv
// One exp2 factor: multiply the Q1.30 mantissa by 2^(2^-K) when fraction
// bit K is set. Depends on lgp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lgp_exp_stage import lgp_pkg::*; #(
   parameter int K = 1
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                adv,
   input  lgp_ctl_type         up_ctl,
   input  logic [LOG_FRAC-1:0] up_f,
   input  logic [MANT_W-1:0]   up_m,
   output lgp_ctl_type         dn_ctl,
   output logic [LOG_FRAC-1:0] dn_f,
   output logic [MANT_W-1:0]   dn_m
);

   localparam logic [MANT_W-1:0] FACTOR = lgp_pow_factor(K);

   logic [2*MANT_W-1:0] prod;
   logic [MANT_W-1:0]   m_in, m_ff;
   lgp_ctl_type         ctl_ff;
   logic [LOG_FRAC-1:0] f_ff;

   assign prod = (2*MANT_W)'(up_m) * (2*MANT_W)'(FACTOR);
   assign m_in = up_f[LOG_FRAC-K] ? prod[MANT_FRAC+MANT_W-1:MANT_FRAC] : up_m;

   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (adv) begin
         ctl_ff <= up_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         f_ff <= up_f;
         m_ff <= m_in;
      end
   end

   assign dn_ctl = ctl_ff;
   assign dn_f   = f_ff;
   assign dn_m   = m_ff;

endmodule

`default_nettype wire

FILE: rtl/luma_gamma_pixel_core.sv
// Top level of the gamma-corrected luminance core. Depends on lgp_pkg,
// lgp_if, lgp_front, lgp_log_stage, lgp_mid and lgp_exp_stage.
//
// Usage:
//   req_bus  pixel in: red_in, green_in, blue_in (CHANNEL_BITS each).
//   rsp_bus  one result per pixel: gray_out (CHANNEL_BITS) and clamped.
//   csr_bus  write of gamma_exponent, unsigned Q4.12; write only while idle.
//   Every channel moves an item at a rising edge with valid and ready high.
// Pipeline: 63 register stages (3 front stages, 28 log2 squaring stages,
//   3 scaling stages, 28 exp2 multiply stages and the output register).
//   The log2 and exp2 stages each hold one 31x31 multiply.
// Throughput: one pixel per clock while rsp_bus.ready keeps the pipe moving;
//   items are independent. Reset: all valid bits clear, the pipe is empty,
//   gamma_exponent = 1.4 (5734). No ready is given while reset is high.
// Stall: the whole pipe advances only when the output register is empty or
//   being taken, so a held rsp_bus.ready freezes every stage and drops
//   req_bus.ready; nothing is lost or repeated.
`timescale 1ns / 1ps
`default_nettype none

module luma_gamma_pixel_core import lgp_pkg::*; #(
   parameter int CHANNEL_BITS = LGP_CHANNEL_BITS_DEF
) (
   input  logic       clock,
   input  logic       reset,
   lgp_req_if.sink    req_bus,
   lgp_rsp_if.source  rsp_bus,
   lgp_csr_if.sink    csr_bus
);

   localparam int LUMA_W = CHANNEL_BITS + LUMA_FRAC;
   localparam int P_W    = $clog2(LUMA_W);
   localparam int NB     = $clog2(CHANNEL_BITS);
   localparam int V_W    = MANT_W + (1 << NB) - 1;
   localparam logic [CHANNEL_BITS-1:0] GRAY_MAX = {CHANNEL_BITS{1'b1}};
   localparam logic [V_W-1:0] SAT_LIMIT =
      {{(V_W - CHANNEL_BITS){1'b0}}, GRAY_MAX} << MANT_FRAC;
   localparam logic [MANT_W-1:0] MANT_ONE = MANT_W'(1) << MANT_FRAC;

   logic                    adv;
   logic [GAMMA_W-1:0]      gamma_ff;
   logic                    rsp_valid_ff;
   logic [CHANNEL_BITS-1:0] gray_in, gray_ff;
   logic                    clamped_in, clamped_ff;

   lgp_ctl_type             log_ctl  [LOG_FRAC+1];
   logic [P_W-1:0]          log_p    [LOG_FRAC+1];
   logic [MANT_W-1:0]       log_x    [LOG_FRAC+1];
   logic [LOG_FRAC-1:0]     log_frac [LOG_FRAC+1];

   lgp_ctl_type             exp_ctl  [LOG_FRAC+1];
   logic [LOG_FRAC-1:0]     exp_f    [LOG_FRAC+1];
   logic [MANT_W-1:0]       exp_m    [LOG_FRAC+1];

   lgp_ctl_type             fin_ctl;
   logic [MANT_W-1:0]       fin_m;
   logic [V_W-1:0]          v_pos, v_neg, v_sel;
   logic                    sat;

   assign adv           = !rsp_valid_ff || rsp_bus.ready;
   assign req_bus.ready = adv && !reset;
   assign csr_bus.ready = !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= LGP_GAMMA_RESET;
      end else if (csr_bus.valid) begin
         gamma_ff <= csr_bus.gamma_exponent;
      end
   end

   lgp_front #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .LUMA_W       (LUMA_W),
      .P_W          (P_W)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .adv      (adv),
      .up_valid (req_bus.valid && req_bus.ready),
      .red_in   (req_bus.red_in),
      .green_in (req_bus.green_in),
      .blue_in  (req_bus.blue_in),
      .dn_ctl   (log_ctl[0]),
      .dn_p     (log_p[0]),
      .dn_x     (log_x[0])
   );

   assign log_frac[0] = '0;

   for (genvar i = 0; i < LOG_FRAC; i++) begin : g_log
      lgp_log_stage #(.P_W(P_W)) u_log (
         .clock   (clock),
         .reset   (reset),
         .adv     (adv),
         .up_ctl  (log_ctl[i]),
         .up_p    (log_p[i]),
         .up_x    (log_x[i]),
         .up_frac (log_frac[i]),
         .dn_ctl  (log_ctl[i+1]),
         .dn_p    (log_p[i+1]),
         .dn_x    (log_x[i+1]),
         .dn_frac (log_frac[i+1])
      );
   end

   lgp_mid #(
      .CHANNEL_BITS (CHANNEL_BITS),
      .P_W          (P_W)
   ) u_mid (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .gamma   (gamma_ff),
      .up_ctl  (log_ctl[LOG_FRAC]),
      .up_p    (log_p[LOG_FRAC]),
      .up_frac (log_frac[LOG_FRAC]),
      .dn_ctl  (exp_ctl[0]),
      .dn_f    (exp_f[0])
   );

   assign exp_m[0] = MANT_ONE;

   for (genvar k = 1; k <= LOG_FRAC; k++) begin : g_exp
      lgp_exp_stage #(.K(k)) u_exp (
         .clock  (clock),
         .reset  (reset),
         .adv    (adv),
         .up_ctl (exp_ctl[k-1]),
         .up_f   (exp_f[k-1]),
         .up_m   (exp_m[k-1]),
         .dn_ctl (exp_ctl[k]),
         .dn_f   (exp_f[k]),
         .dn_m   (exp_m[k])
      );
   end

   assign fin_ctl = exp_ctl[LOG_FRAC];
   assign fin_m   = exp_m[LOG_FRAC];

   // result keeps 30 fraction bits; gray is the integer part
   assign v_pos = V_W'(fin_m) << fin_ctl.shamt[NB-1:0];
   assign v_neg = fin_ctl.shz ? '0 : V_W'(fin_m >> fin_ctl.shamt);
   assign v_sel = fin_ctl.neg ? v_neg : v_pos;
   assign sat   = !fin_ctl.neg && (fin_ctl.big || (v_pos > SAT_LIMIT));

   always_comb begin
      priority if (fin_ctl.zero) begin
         gray_in    = '0;
         clamped_in = 1'b0;
      end else if (sat) begin
         gray_in    = GRAY_MAX;
         clamped_in = 1'b1;
      end else begin
         gray_in    = v_sel[MANT_FRAC +: CHANNEL_BITS];
         clamped_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= fin_ctl.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gray_ff    <= gray_in;
         clamped_ff <= clamped_in;
      end
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.gray_out = gray_ff;
   assign rsp_bus.clamped  = clamped_ff;

   a_clamp_is_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && clamped_ff |-> gray_ff == GRAY_MAX)
      else $error("clamped result without saturated gray");

   a_zero_luma: assert property (@(posedge clock) disable iff (reset)
      fin_ctl.valid && fin_ctl.zero && adv
      |=> rsp_valid_ff && gray_ff == '0 && !clamped_ff)
      else $error("zero luminance did not give a zero result");

   a_big_clamps: assert property (@(posedge clock) disable iff (reset)
      fin_ctl.valid && !fin_ctl.zero && !fin_ctl.neg && fin_ctl.big && adv
      |=> clamped_ff)
      else $error("oversized exponent not clamped");

   a_neg_small: assert property (@(posedge clock) disable iff (reset)
      fin_ctl.valid && fin_ctl.neg && adv
      |=> !clamped_ff && gray_ff <= CHANNEL_BITS'(1))
      else $error("negative exponent gave a large result");

endmodule

`default_nettype wire
